// File: design/qra_pkg.sv
`default_nettype none

package qra_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_MULT_X          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MULT_SKIP       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_SHIFT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_POINT_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_POINT_SKIP = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_POINT_OUT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RELU_ENABLE     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_WIDE_MODE       = 3'd7;

    // Datapath widths
    localparam int unsigned ELEM_W = 16;   // element and result
    localparam int unsigned DIFF_W = 17;   // element minus zero point
    localparam int unsigned MULT_W = 32;
    localparam int unsigned PROD_W = 49;   // DIFF_W + MULT_W
    localparam int unsigned ACC_W  = 50;   // sum of two products
    localparam int unsigned TRN_W  = 32;   // shifted sum after truncation
    localparam int unsigned OFS_W  = 34;   // truncated sum plus output zero point

    // Saturation bounds, held at offset-sum width
    localparam logic signed [OFS_W-1:0] I8_MIN  = -34'sd128;
    localparam logic signed [OFS_W-1:0] I8_MAX  = 34'sd127;
    localparam logic signed [OFS_W-1:0] I16_MIN = -34'sd32768;
    localparam logic signed [OFS_W-1:0] I16_MAX = 34'sd32767;

    typedef logic signed [ELEM_W-1:0] t_elem;

endpackage

`default_nettype wire

// File: design/quantized_residual_add.sv
`default_nettype none

// Channel     Direction  Ports                                          Handshake
// ----------  ---------  ---------------------------------------------  -------------------------
// input       in         i_x_value, i_skip_value, i_last_in             start high, busy low
// result      out        o_out_value, o_last_out                        o_valid, one cycle, no hold
// config      in         i_cfg_we, i_cfg_idx, i_cfg_data                write at edge with i_cfg_we
//
// One transaction is accepted per cycle; busy is tied low since nothing blocks the input.
// Each result passes through one register per stage, in this order:
// input register (zero point removal), product register (two 17x32 multipliers),
// sum register (50-bit add and arithmetic shift), result register (offset, relu, clamp).
// Synchronous active-low reset clears the stage valid bits; the configuration registers
// reset to zero. The receiver cannot stall, so no result is ever held back.

module quantized_residual_add (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               start,
    output logic                              busy,
    input  wire  signed [qra_pkg::ELEM_W-1:0] i_x_value,
    input  wire  signed [qra_pkg::ELEM_W-1:0] i_skip_value,
    input  wire                               i_last_in,
    output logic                              o_valid,
    output logic signed [qra_pkg::ELEM_W-1:0] o_out_value,
    output logic                              o_last_out,
    input  wire                               i_cfg_we,
    input  wire         [qra_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire         [qra_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import qra_pkg::*;

    // Configuration registers
    logic signed [MULT_W-1:0] r_mult_x;
    logic signed [MULT_W-1:0] r_mult_skip;
    logic        [5:0]        r_shift;
    logic signed [7:0]        r_zp_x;
    logic signed [7:0]        r_zp_skip;
    logic signed [7:0]        r_zp_out;
    logic                     r_relu;
    logic                     r_wide;

    // Pipeline registers
    logic                     r_v1, r_v2, r_v3, r_v4;
    logic                     r_last1, r_last2, r_last3, r_last4;
    logic signed [DIFF_W-1:0] r_dx, r_ds;
    logic signed [PROD_W-1:0] r_px, r_ps;
    logic signed [TRN_W-1:0]  r_trn;
    t_elem                    r_out;

    // Next values
    t_elem                    n_xv, n_sv;
    logic signed [DIFF_W-1:0] n_dx, n_ds;
    logic signed [PROD_W-1:0] n_px, n_ps;
    logic signed [ACC_W-1:0]  n_acc, n_sh;
    logic signed [OFS_W-1:0]  n_ofs, n_rl, n_lo, n_hi;
    t_elem                    n_out;
    logic                     n_accept;

    assign busy     = 1'b0;
    assign n_accept = start && !busy;

    // Configuration writes: apply at once; write only while the pipeline is empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mult_x    <= '0;
            r_mult_skip <= '0;
            r_shift     <= '0;
            r_zp_x      <= '0;
            r_zp_skip   <= '0;
            r_zp_out    <= '0;
            r_relu      <= 1'b0;
            r_wide      <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MULT_X:          r_mult_x    <= i_cfg_data;
                REG_MULT_SKIP:       r_mult_skip <= i_cfg_data;
                REG_RIGHT_SHIFT:     r_shift     <= i_cfg_data[5:0];
                REG_ZERO_POINT_X:    r_zp_x      <= i_cfg_data[7:0];
                REG_ZERO_POINT_SKIP: r_zp_skip   <= i_cfg_data[7:0];
                REG_ZERO_POINT_OUT:  r_zp_out    <= i_cfg_data[7:0];
                REG_RELU_ENABLE:     r_relu      <= i_cfg_data[0];
                REG_WIDE_MODE:       r_wide      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Stage 1: narrow elements to int8 in narrow mode, drop zero point
    always_comb begin
        n_xv = r_wide ? i_x_value    : t_elem'({{8{i_x_value[7]}},    i_x_value[7:0]});
        n_sv = r_wide ? i_skip_value : t_elem'({{8{i_skip_value[7]}}, i_skip_value[7:0]});
        n_dx = $signed({n_xv[ELEM_W-1], n_xv}) - $signed({{9{r_zp_x[7]}}, r_zp_x});
        n_ds = $signed({n_sv[ELEM_W-1], n_sv}) - $signed({{9{r_zp_skip[7]}}, r_zp_skip});
    end

    // Stage 2: one multiplier per branch
    always_comb begin
        n_px = PROD_W'(r_dx) * PROD_W'(r_mult_x);
        n_ps = PROD_W'(r_ds) * PROD_W'(r_mult_skip);
    end

    // Stage 3: exact sum, arithmetic shift, keep the low 32 bits
    always_comb begin
        n_acc = $signed({r_px[PROD_W-1], r_px}) + $signed({r_ps[PROD_W-1], r_ps});
        n_sh  = n_acc >>> r_shift;
    end

    // Stage 4: add output zero point, relu, then clamp by mode
    always_comb begin
        n_ofs = $signed({{2{r_trn[TRN_W-1]}}, r_trn}) + $signed({{26{r_zp_out[7]}}, r_zp_out});
        n_rl  = (r_relu && n_ofs[OFS_W-1]) ? '0 : n_ofs;
        n_lo  = r_wide ? I16_MIN : I8_MIN;
        n_hi  = r_wide ? I16_MAX : I8_MAX;
        if (n_rl < n_lo) begin
            n_out = n_lo[ELEM_W-1:0];
        end else if (n_rl > n_hi) begin
            n_out = n_hi[ELEM_W-1:0];
        end else begin
            n_out = n_rl[ELEM_W-1:0];
        end
    end

    // Valid bits: advance one stage a cycle, clear on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= n_accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // Payload: advance freely, no reset
    always_ff @(posedge i_clk) begin
        r_dx    <= n_dx;
        r_ds    <= n_ds;
        r_last1 <= i_last_in;
        r_px    <= n_px;
        r_ps    <= n_ps;
        r_last2 <= r_last1;
        r_trn   <= n_sh[TRN_W-1:0];
        r_last3 <= r_last2;
        r_out   <= n_out;
        r_last4 <= r_last3;
    end

    assign o_valid     = r_v4;
    assign o_out_value = r_out;
    assign o_last_out  = r_last4;

    // Each accepted transaction emerges after every stage register, with its last flag
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n, 1) && $past(i_rst_n, 2) && $past(i_rst_n, 3) && $past(i_rst_n, 4))
        |-> (o_valid == $past(start, 4)))
        else $error("result strobe does not follow accepted transaction");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n, 1) && $past(i_rst_n, 2) && $past(i_rst_n, 3) && $past(i_rst_n, 4)
         && o_valid) |-> (o_last_out == $past(i_last_in, 4)))
        else $error("last flag lost in pipeline");

    a_narrow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_v3 && !r_wide) |->
            ($signed(o_out_value) >= -16'sd128 && $signed(o_out_value) <= 16'sd127))
        else $error("int8 result out of range");

    a_relu: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_v3 && r_relu) |-> !o_out_value[ELEM_W-1])
        else $error("negative result with relu enabled");

endmodule

`default_nettype wire
